// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the pose and event frame parser.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("invariant violated");

// The antecedent implies the consequent in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication violated");

`endif

// ===== rtl/pefp_pkg.sv =====
// Package of the pose and event frame parser: byte codes, frame sizes,
// parser state type and the result record. No dependencies.
`default_nettype none

package pefp_pkg;

  // Byte codes on the link.
  localparam logic [7:0] POSE_HEAD  = 8'hFB;
  localparam logic [7:0] EVENT_HEAD = 8'hFD;
  localparam logic [7:0] EVENT_FLAG = 8'h01;
  localparam logic [7:0] FRAME_TAIL = 8'h0D;

  // Length of an event frame in bytes.
  localparam int unsigned EVENT_FRAME_BYTES = 3;

  // Frame kind codes carried in a result.
  localparam logic KIND_POSE  = 1'b0;
  localparam logic KIND_EVENT = 1'b1;

  // Parser state: which frame, if any, is being collected.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POSE,
    ST_EVENT
  } state_e;

  // One result item.
  typedef struct packed {
    logic               frame_kind;
    logic signed [15:0] pose_x;
    logic signed [15:0] pose_y;
    logic signed [15:0] pose_z;
    logic signed [15:0] pose_yaw;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/pefp_byte_cell.sv =====
// One byte cell of the receive shift chain of the frame parser.
// Depends on nothing; instantiated in a row by the top level.
`default_nettype none

module pefp_byte_cell (
  input  wire logic       clk_i,
  input  wire logic       shift_i,
  input  wire logic [7:0] byte_i,
  output logic      [7:0] byte_o
);

  logic [7:0] byte_q;

  // Take the byte on byte_i (the previous cell, or the link byte for cell 0) on every transfer into the parser.
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      byte_q <= byte_i;
    end
  end

  assign byte_o = byte_q;

endmodule

`default_nettype wire

// ===== rtl/pose_and_event_frame_parser.sv =====
// Transfer of the final frame byte registers the result into the output or skid entry.
// Throughput: one byte per cycle; results leave through a two-entry output buffer and
// in_stall_o rises only when both entries are full, i.e. after the output has stalled.
// Frame bytes travel down a row of byte cells, one cell further per accepted byte.
// Reset (rst_ni, asynchronous, active low) returns the parser to idle and empties the
// output buffer; the byte cells keep their contents.
`default_nettype none

module pose_and_event_frame_parser #(
  parameter int unsigned POSE_FRAME_BYTES = 10
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [7:0]         rx_byte_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic                    frame_kind_o,
  output logic signed [15:0]      pose_x_o,
  output logic signed [15:0]      pose_y_o,
  output logic signed [15:0]      pose_z_o,
  output logic signed [15:0]      pose_yaw_o
);

  import pefp_pkg::*;

  `include "assert_macros.svh"

  // Cells hold the payload bytes between head and tail of a pose frame.
  localparam int unsigned NumCells = POSE_FRAME_BYTES - 2;
  localparam int unsigned CntW     = $clog2(POSE_FRAME_BYTES);
  localparam logic [CntW-1:0] PoseLast  = CntW'(POSE_FRAME_BYTES - 1);
  localparam logic [CntW-1:0] EventLast = CntW'(EVENT_FRAME_BYTES - 1);

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            in_fire;
  logic            frame_done;
  logic            res_valid;
  result_t         res;
  logic [7:0]      cell_byte [NumCells];

  logic            out_valid_q, out_valid_d;
  logic            skid_valid_q, skid_valid_d;
  logic            out_fire;
  result_t         out_q, skid_q;

  assign in_fire  = in_valid_i && !skid_valid_q;
  assign out_fire = out_valid_q && !out_stall_i;

  // Row of byte cells; cell 0 takes the incoming byte.
  for (genvar gi = 0; gi < NumCells; gi++) begin : g_cell
    logic [7:0] cell_in;
    if (gi == 0) begin : g_first
      assign cell_in = rx_byte_i;
    end else begin : g_next
      assign cell_in = cell_byte[gi-1];
    end
    pefp_byte_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (in_fire),
      .byte_i  (cell_in),
      .byte_o  (cell_byte[gi])
    );
  end

  // The current byte is the last one of the frame being collected.
  assign frame_done = ((state_q == ST_POSE) && (cnt_q == PoseLast)) ||
                      ((state_q == ST_EVENT) && (cnt_q == EventLast));

  // Next state: count bytes; at frame end or in idle a head byte opens a frame, any other byte goes idle.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    if (in_fire) begin
      if ((state_q == ST_IDLE) || frame_done) begin
        priority if (rx_byte_i == POSE_HEAD) begin
          state_d = ST_POSE;
          cnt_d   = CntW'(1);
        end else if (rx_byte_i == EVENT_HEAD) begin
          state_d = ST_EVENT;
          cnt_d   = CntW'(1);
        end else begin
          state_d = ST_IDLE;
          cnt_d   = '0;
        end
      end else begin
        cnt_d = cnt_q + CntW'(1);
      end
    end
  end

  // Outputs: check the finished frame and assemble the result.
  always_comb begin
    res_valid    = 1'b0;
    res          = '0;
    unique case (state_q)
      ST_POSE: begin
        res.frame_kind = KIND_POSE;
        res.pose_x     = {cell_byte[NumCells-1], cell_byte[NumCells-2]};
        res.pose_y     = {cell_byte[NumCells-3], cell_byte[NumCells-4]};
        res.pose_z     = {cell_byte[NumCells-5], cell_byte[NumCells-6]};
        res.pose_yaw   = {cell_byte[NumCells-7], cell_byte[NumCells-8]};
        res_valid      = in_fire && frame_done && (rx_byte_i == FRAME_TAIL);
      end
      ST_EVENT: begin
        res.frame_kind = KIND_EVENT;
        res_valid      = in_fire && frame_done && (cell_byte[0] == EVENT_FLAG) &&
                         (rx_byte_i == FRAME_TAIL);
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Output buffer: the main register feeds the port, the skid entry catches a
  // result that arrives while the port is stalled.
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (!out_valid_q || out_fire) begin
      out_valid_d  = skid_valid_q || res_valid;
      skid_valid_d = 1'b0;
    end else if (res_valid) begin
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_fire) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (res_valid) begin
      skid_q <= res;
    end
  end

  assign in_stall_o   = skid_valid_q;
  assign out_valid_o  = out_valid_q;
  assign frame_kind_o = out_q.frame_kind;
  assign pose_x_o     = out_q.pose_x;
  assign pose_y_o     = out_q.pose_y;
  assign pose_z_o     = out_q.pose_z;
  assign pose_yaw_o   = out_q.pose_yaw;

  // The skid entry is only ever filled behind a stalled main register.
  `ASSERT_IMPLIES(a_skid_behind_out, clk_i, rst_ni, skid_valid_q, out_valid_q)
  // The byte count is zero exactly when no frame is being collected.
  `ASSERT_ALWAYS(a_idle_count, clk_i, rst_ni, (state_q == ST_IDLE) == (cnt_q == '0))
  // A result comes only from a frame that completes on this transfer.
  `ASSERT_IMPLIES(a_result_at_end, clk_i, rst_ni, res_valid, in_fire && frame_done)

endmodule

`default_nettype wire

// ===== tb/pefp_frame_checker.sv =====
`timescale 1ns / 100ps
// Frame checker for the pose and event frame parser: it follows the byte and result
// channels, predicts each frame result from the accepted bytes and compares them.
// Depends on pefp_pkg for the byte codes, the parser state type and result_t.

module pefp_frame_checker #(
  parameter int unsigned POSE_FRAME_BYTES = 10
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               in_stall_i,
  input  wire logic [7:0]         rx_byte_i,
  input  wire logic               out_valid_i,
  input  wire logic               out_stall_i,
  input  wire logic               frame_kind_i,
  input  wire logic signed [15:0] pose_x_i,
  input  wire logic signed [15:0] pose_y_i,
  input  wire logic signed [15:0] pose_z_i,
  input  wire logic signed [15:0] pose_yaw_i,
  output int                      mismatches_o,
  output int                      results_due_o,
  output int                      bytes_seen_o,
  output int                      poses_seen_o,
  output int                      events_seen_o
);

  import pefp_pkg::*;

  localparam int PRINT_CAP = 50;

  // Predicted results that have not yet left the parser, oldest first.
  result_t    frame_results_due [$];

  // Predictor state: frame being collected, bytes held so far, and the byte store.
  state_e     frame_mode;
  logic [3:0] held_count;
  logic [7:0] frame_store [POSE_FRAME_BYTES];

  // Count a fault and print it, up to a cap so a broken block cannot flood the log.
  task automatic log_fault(input string msg);
    mismatches_o++;
    if (mismatches_o <= PRINT_CAP) begin
      $display("[%0t] frame check: %s", $time, msg);
    end
  endtask

  task automatic compare_word(input string field, input logic [15:0] got,
                              input logic [15:0] want);
    if (got !== want) begin
      log_fault($sformatf("%s is %h, predicted %h", field, got, want));
    end
  endtask

  // A head byte opens a frame of the length that head implies; anything else means idle.
  task automatic open_frame_or_idle(input logic [7:0] b);
    if (b == POSE_HEAD) begin
      frame_mode     = ST_POSE;
      frame_store[0] = b;
      held_count     = 4'd1;
    end else if (b == EVENT_HEAD) begin
      frame_mode     = ST_EVENT;
      frame_store[0] = b;
      held_count     = 4'd1;
    end else begin
      frame_mode = ST_IDLE;
      held_count = 4'd0;
    end
  endtask

  // Advance the predictor by one accepted byte and queue any frame result it completes.
  task automatic parse_link_byte(input logic [7:0] b);
    logic [3:0] need_len;
    result_t    res;
    if (held_count == 4'd0) begin
      open_frame_or_idle(b);
    end else begin
      if (held_count < POSE_FRAME_BYTES) begin
        frame_store[held_count] = b;
      end
      held_count = held_count + 4'd1;
      need_len   = (frame_mode == ST_POSE) ? 4'(POSE_FRAME_BYTES) : 4'(EVENT_FRAME_BYTES);
      if (held_count >= need_len) begin
        // Only a correct tail or a correct event body yields a result.
        if (frame_mode == ST_POSE && frame_store[POSE_FRAME_BYTES - 1] == FRAME_TAIL) begin
          res.frame_kind = KIND_POSE;
          res.pose_x     = {frame_store[1], frame_store[2]};
          res.pose_y     = {frame_store[3], frame_store[4]};
          res.pose_z     = {frame_store[5], frame_store[6]};
          res.pose_yaw   = {frame_store[7], frame_store[8]};
          frame_results_due.push_back(res);
        end else if (frame_mode == ST_EVENT && frame_store[0] == EVENT_HEAD &&
                     frame_store[1] == EVENT_FLAG && frame_store[2] == FRAME_TAIL) begin
          res            = '0;
          res.frame_kind = KIND_EVENT;
          frame_results_due.push_back(res);
        end
        // The final byte may itself open the next frame, valid frame or not.
        open_frame_or_idle(b);
      end
    end
  endtask

  // Compare one result transfer with the oldest prediction.
  task automatic check_result();
    result_t want;
    if (frame_results_due.size() == 0) begin
      log_fault($sformatf("result of kind %0d arrived with no frame due", frame_kind_i));
    end else begin
      want = frame_results_due.pop_front();
      if (want.frame_kind == KIND_POSE) begin
        poses_seen_o++;
      end else begin
        events_seen_o++;
      end
      if (frame_kind_i !== want.frame_kind) begin
        log_fault($sformatf("frame_kind is %b, predicted %b", frame_kind_i, want.frame_kind));
      end
      compare_word("pose_x", pose_x_i, want.pose_x);
      compare_word("pose_y", pose_y_i, want.pose_y);
      compare_word("pose_z", pose_z_i, want.pose_z);
      compare_word("pose_yaw", pose_yaw_i, want.pose_yaw);
    end
  endtask

  // Watch both channels at each rising edge; results are checked before the byte of the
  // same edge is taken, since a byte's own result is registered and leaves later.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_mode = ST_IDLE;
      held_count = 4'd0;
      for (int k = 0; k < POSE_FRAME_BYTES; k++) begin
        frame_store[k] = 8'h00;
      end
      frame_results_due.delete();
      results_due_o = 0;
    end else begin
      if (out_valid_i === 1'b1 && out_stall_i == 1'b0) begin
        check_result();
      end
      if (in_valid_i == 1'b1 && in_stall_i === 1'b0) begin
        bytes_seen_o++;
        parse_link_byte(rx_byte_i);
      end
      results_due_o = frame_results_due.size();
    end
  end

endmodule

// ===== tb/pose_and_event_frame_parser_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the pose and event frame parser: drives link bytes with random
// gaps and output stalls, and gives the verdict from pefp_frame_checker.
// Depends on pefp_pkg, pefp_frame_checker and the parser RTL.

module pose_and_event_frame_parser_tb;
  import pefp_pkg::*;

  localparam int unsigned POSE_BYTES   = 10;
  localparam int unsigned ITEM_TARGET  = 1050;
  localparam int unsigned CYCLE_LIMIT  = 400_000;
  localparam int unsigned DRAIN_CYCLES = 80;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  logic [7:0]         rx_byte_i   = 8'h00;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               frame_kind_o;
  logic signed [15:0] pose_x_o;
  logic signed [15:0] pose_y_o;
  logic signed [15:0] pose_z_o;
  logic signed [15:0] pose_yaw_o;

  int          mismatches;
  int          results_due;
  int          bytes_seen;
  int          poses_seen;
  int          events_seen;
  int unsigned bytes_sent   = 0;
  int unsigned cycle_count  = 0;
  bit          sender_quiet = 1'b0;

  pose_and_event_frame_parser #(
    .POSE_FRAME_BYTES(POSE_BYTES)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .rx_byte_i   (rx_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .frame_kind_o(frame_kind_o),
    .pose_x_o    (pose_x_o),
    .pose_y_o    (pose_y_o),
    .pose_z_o    (pose_z_o),
    .pose_yaw_o  (pose_yaw_o)
  );

  pefp_frame_checker #(
    .POSE_FRAME_BYTES(POSE_BYTES)
  ) frame_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .rx_byte_i    (rx_byte_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .frame_kind_i (frame_kind_o),
    .pose_x_i     (pose_x_o),
    .pose_y_i     (pose_y_o),
    .pose_z_i     (pose_z_o),
    .pose_yaw_i   (pose_yaw_o),
    .mismatches_o (mismatches),
    .results_due_o(results_due),
    .bytes_seen_o (bytes_seen),
    .poses_seen_o (poses_seen),
    .events_seen_o(events_seen)
  );

  // Free-running clock, 2 ns period.
  initial begin : clock_gen
    forever #1 clk_i = ~clk_i;
  end

  // Guard against a hung handshake.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d results outstanding.",
               cycle_count, results_due);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Gap before a byte: mostly none, some short, a few long; none in quiet stretches.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (sender_quiet || roll < 65) begin
      return 0;
    end else if (roll < 95) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Frame payload byte: mostly uniform, sometimes a link code or an edge value.
  function automatic logic [7:0] payload_byte();
    if ($urandom_range(0, 99) >= 15) begin
      return 8'($urandom_range(0, 255));
    end
    case ($urandom_range(0, 7))
      0:       return POSE_HEAD;
      1:       return EVENT_HEAD;
      2:       return FRAME_TAIL;
      3:       return EVENT_FLAG;
      4:       return 8'h00;
      5:       return 8'hFF;
      6:       return 8'h80;
      default: return 8'h7F;
    endcase
  endfunction

  // Offer one byte at a falling edge and hold it until the transfer completes.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  // Output stall: ready runs of random length, mostly short stalls, a few long ones.
  initial begin : out_stall_gen
    int unsigned free_run;
    int unsigned hold_run;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      free_run = ($urandom_range(0, 19) == 0) ? $urandom_range(80, 300)
                                              : $urandom_range(1, 12);
      hold_run = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60)
                                             : $urandom_range(1, 3);
      out_stall_i <= 1'b0;
      repeat (free_run) @(negedge clk_i);
      out_stall_i <= 1'b1;
      repeat (hold_run) @(negedge clk_i);
    end
  end

  // Reset, directed opening, random frames, then drain and verdict.
  initial begin : stimulus
    logic [7:0]  burst [$];
    logic [7:0]  tail;
    int unsigned pick;
    int unsigned spot;

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Ignored idle bytes, a pose frame at the signed extremes, a clean event frame,
    // a broken event body ending in a pose head, a pose frame with head bytes inside
    // and a bad tail that is an event head, then the event that head opened.
    burst = '{8'h00, 8'hFF,
              POSE_HEAD, 8'h80, 8'h00, 8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, FRAME_TAIL,
              EVENT_HEAD, EVENT_FLAG, FRAME_TAIL,
              EVENT_HEAD, EVENT_FLAG, POSE_HEAD,
              EVENT_HEAD, POSE_HEAD, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 8'hBC, EVENT_HEAD,
              EVENT_FLAG, FRAME_TAIL};
    foreach (burst[k]) send_byte(burst[k]);

    // Random part: mostly well-formed frames with random content, plus broken
    // frames and line noise.
    while (bytes_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 19) == 0) begin
        sender_quiet = !sender_quiet;
      end
      pick = $urandom_range(0, 99);
      burst.delete();
      if (pick < 45) begin
        burst.push_back(POSE_HEAD);
        repeat (8) burst.push_back(payload_byte());
        burst.push_back(FRAME_TAIL);
      end else if (pick < 70) begin
        burst = '{EVENT_HEAD, EVENT_FLAG, FRAME_TAIL};
      end else if (pick < 80) begin
        // Pose frame with a wrong tail, sometimes a head byte.
        tail = ($urandom_range(0, 2) == 0) ? (($urandom_range(0, 1) == 0) ? POSE_HEAD
                                                                          : EVENT_HEAD)
                                           : 8'($urandom_range(0, 255));
        if (tail == FRAME_TAIL) begin
          tail = ~tail;
        end
        burst.push_back(POSE_HEAD);
        repeat (8) burst.push_back(payload_byte());
        burst.push_back(tail);
      end else if (pick < 88) begin
        // Event frame with one corrupted byte after the head.
        burst = '{EVENT_HEAD, EVENT_FLAG, FRAME_TAIL};
        spot  = $urandom_range(1, 2);
        if ($urandom_range(0, 3) == 0) begin
          burst[spot] = ($urandom_range(0, 1) == 0) ? POSE_HEAD : EVENT_HEAD;
        end else begin
          burst[spot] = 8'($urandom_range(0, 255));
          if (burst[spot] == ((spot == 1) ? EVENT_FLAG : FRAME_TAIL)) begin
            burst[spot] = ~burst[spot];
          end
        end
      end else begin
        repeat ($urandom_range(1, 4)) burst.push_back(8'($urandom_range(0, 255)));
      end
      foreach (burst[k]) send_byte(burst[k]);
    end
    in_valid_i <= 1'b0;

    // Drain: wait for every predicted result, then give any stray result time to
    // leave past the longest output stall.
    while (results_due != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (results_due != 0) begin
      $display("%0d predicted frame results never left the parser.", results_due);
    end
    $display("Checked %0d link bytes in %0d cycles: %0d pose and %0d event results.",
             bytes_seen, cycle_count, poses_seen, events_seen);
    $display("Field or ordering faults found: %0d.", mismatches);
    if (mismatches == 0 && results_due == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
